[rtl/core/assert_macros.svh]
// Assertion macros for the RTL that checks itself.
// Both macros sample on the rising edge of clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property outside of reset.
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Constants and types of the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int QUEUE_DEPTH   = 16;
  localparam int KEY_WIDTH     = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);

  // operation codes of the request word
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef logic [CNT_W-1:0] count_t;

  typedef struct packed {
    logic [KEY_WIDTH-1:0]     key;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } entry_t;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic   en;             // update the chain this cycle
    logic   push;           // 1 insert, 0 remove the head
    logic   largest_first;  // serve order
    entry_t new_entry;      // entry to insert
  } cell_ctl_t;

endpackage

[rtl/core/spq_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_req_if
// Request channel: push or pop word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_req_if;
  logic                              valid;
  logic                              ready;
  logic                              mode;
  logic [spq_pkg::KEY_WIDTH-1:0]     item_key;
  logic [spq_pkg::PAYLOAD_WIDTH-1:0] item_payload;

  modport source (output valid, output mode, output item_key, output item_payload,
                  input ready);
  modport sink   (input valid, input mode, input item_key, input item_payload,
                  output ready);
endinterface

[rtl/core/spq_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_rsp_if
// Response channel: operation status and head of queue, valid/ready handshake.
// ----------------------------------------------------------------------------
interface spq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic                              ok;
  logic [spq_pkg::KEY_WIDTH-1:0]     popped_key;
  logic [spq_pkg::PAYLOAD_WIDTH-1:0] popped_payload;
  logic                              head_valid;
  logic [spq_pkg::KEY_WIDTH-1:0]     head_key;
  logic [spq_pkg::PAYLOAD_WIDTH-1:0] head_payload;
  logic [spq_pkg::CNT_W-1:0]         entry_count;

  modport source (output valid, output ok, output popped_key, output popped_payload,
                  output head_valid, output head_key, output head_payload,
                  output entry_count, input ready);
  modport sink   (input valid, input ok, input popped_key, input popped_payload,
                  input head_valid, input head_key, input head_payload,
                  input entry_count, output ready);
endinterface

[rtl/core/spq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the ordered chain: compare, then hold, take new or shift.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               valid,       // slot holds an entry
  input  logic               found_in,    // insert point lies left of this slot
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output logic               found_out,
  output spq_pkg::entry_t    entry,
  output spq_pkg::entry_t    entry_next
);

  logic after;

  // held entry must leave after the new one under the current order
  assign after = valid && (ctl.largest_first ? (entry.key < ctl.new_entry.key)
                                             : (entry.key > ctl.new_entry.key));
  assign found_out = found_in || after;

  always_comb begin
    entry_next = entry;
    if (ctl.en) begin
      if (ctl.push) begin
        if (found_in) begin
          entry_next = left_entry;
        end else if (after || !valid) begin
          entry_next = ctl.new_entry;
        end
      end else begin
        entry_next = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

[rtl/core/sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept sorted in a chain of compare-and-shift cells.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          word
//  --------  ---  -----------------  -----------------------------------------
//  req       in   valid/ready        mode, item_key, item_payload
//  rsp       out  valid/ready        ok, popped, head, entry_count
//  cfg       in   cfg_we (no stall)  cfg_wdata = largest_first
//
//  One request word per cycle; every cell compares and moves in the same
//  cycle, and the insert point ripples along the chain as a found flag.
//  The response is registered in the cycle after its request is taken.
//  rst clears the count, the order register and the response valid; cell
//  contents are don't-care until written.
//  A stalled response holds; a new request is taken only when the response
//  register is empty or is being drained in the same cycle.
//
`include "assert_macros.svh"

module sorted_priority_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  spq_req_if.sink     req,
  spq_rsp_if.source   rsp
);

  logic                    largest_first;
  spq_pkg::count_t         count;
  spq_pkg::count_t         count_next;
  logic                    rsp_valid;

  logic                    accept;
  logic                    is_pop;
  logic                    full;
  logic                    empty;
  logic                    op_ok;
  spq_pkg::cell_ctl_t      ctl;

  logic [spq_pkg::QUEUE_DEPTH-1:0] cell_valid;
  logic [spq_pkg::QUEUE_DEPTH:0]   found;
  spq_pkg::entry_t                 cell_entry [spq_pkg::QUEUE_DEPTH];
  spq_pkg::entry_t                 cell_next  [spq_pkg::QUEUE_DEPTH];

  // order register; write only while idle (the block does not enforce it)
  always_ff @(posedge clk) begin
    if (rst) begin
      largest_first <= 1'b0;
    end else if (cfg_we) begin
      largest_first <= cfg_wdata;
    end
  end

  // take a request when the response slot is free or draining
  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign is_pop = (req.mode == spq_pkg::MODE_POP);
  assign full   = (count == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH));
  assign empty  = (count == '0);
  assign op_ok  = is_pop ? !empty : !full;

  assign ctl.en                = accept && op_ok;
  assign ctl.push              = !is_pop;
  assign ctl.largest_first     = largest_first;
  assign ctl.new_entry.key     = req.item_key;
  assign ctl.new_entry.payload = req.item_payload;

  always_comb begin
    count_next = count;
    if (ctl.en) begin
      count_next = is_pop ? count - 1'b1 : count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // the chain: slot 0 is the head; no insert point lies left of it
  assign found[0] = 1'b0;

  for (genvar i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    spq_pkg::entry_t left_e;
    spq_pkg::entry_t right_e;

    assign cell_valid[i] = (spq_pkg::CNT_W'(i) < count);

    if (i == 0) begin : g_first
      assign left_e = ctl.new_entry;
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
    end

    // last slot has no right neighbor: hold its own entry on a pop
    if (i == spq_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign right_e = cell_entry[i];
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .valid       (cell_valid[i]),
      .found_in    (found[i]),
      .left_entry  (left_e),
      .right_entry (right_e),
      .found_out   (found[i+1]),
      .entry       (cell_entry[i]),
      .entry_next  (cell_next[i])
    );
  end

  // response register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.ok <= op_ok;
      if (is_pop && op_ok) begin
        rsp.popped_key     <= cell_entry[0].key;
        rsp.popped_payload <= cell_entry[0].payload;
      end else begin
        rsp.popped_key     <= '0;
        rsp.popped_payload <= '0;
      end
      rsp.head_valid  <= (count_next != '0);
      rsp.entry_count <= count_next;
      if (count_next != '0) begin
        rsp.head_key     <= cell_next[0].key;
        rsp.head_payload <= cell_next[0].payload;
      end else begin
        rsp.head_key     <= '0;
        rsp.head_payload <= '0;
      end
    end
  end

  assign rsp.valid = rsp_valid;

  `SPQ_ASSERT(a_count_bound, count <= spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH), "count over depth")
  `SPQ_ASSERT(a_count_hold, !ctl.en |=> $stable(count), "count moved without an update")
  `SPQ_ASSERT(a_head_flag, rsp_valid |-> (rsp.head_valid == (rsp.entry_count != '0)), "head flag mismatch")
  `SPQ_ASSERT_ALWAYS(a_reset_count, $past(rst) |-> (count == '0 && !rsp_valid), "reset not applied")

endmodule

[tb/sv/spq_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_tb_pkg
// Response word type and the scoreboard of the sorted priority queue bench:
// it keeps its own ordered store, predicts each response and compares.
// ----------------------------------------------------------------------------
package spq_tb_pkg;
  import spq_pkg::*;

  typedef struct packed {
    logic                     ok;
    logic [KEY_WIDTH-1:0]     popped_key;
    logic [PAYLOAD_WIDTH-1:0] popped_payload;
    logic                     head_valid;
    logic [KEY_WIDTH-1:0]     head_key;
    logic [PAYLOAD_WIDTH-1:0] head_payload;
    count_t                   entry_count;
  } rsp_word_t;

  class spq_scoreboard;
    int                       failures = 0;
    bit                       largest_first = 1'b0;
    logic [KEY_WIDTH-1:0]     held_keys     [QUEUE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] held_payloads [QUEUE_DEPTH];
    int                       held = 0;
    rsp_word_t                expected_rsp [$];

    function void set_order(bit value);
      largest_first = value;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // true if key a leaves after key b under the current order
    function bit goes_after(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
      return largest_first ? (a < b) : (a > b);
    endfunction

    // Apply one accepted request word to the store and queue its response.
    function void note_request(logic mode, logic [KEY_WIDTH-1:0] key,
                               logic [PAYLOAD_WIDTH-1:0] payload);
      rsp_word_t w;
      int        pos;
      bit        found;
      w = '0;
      if (mode == MODE_PUSH) begin
        if (held < QUEUE_DEPTH) begin
          pos   = held;
          found = 1'b0;
          // insert before the first held entry that orders after the new key
          for (int i = 0; i < held; i++) begin
            if (!found && goes_after(held_keys[i], key)) begin
              pos   = i;
              found = 1'b1;
            end
          end
          for (int i = held; i > pos; i--) begin
            held_keys[i]     = held_keys[i-1];
            held_payloads[i] = held_payloads[i-1];
          end
          held_keys[pos]     = key;
          held_payloads[pos] = payload;
          held++;
          w.ok = 1'b1;
        end
      end else if (held > 0) begin
        w.ok             = 1'b1;
        w.popped_key     = held_keys[0];
        w.popped_payload = held_payloads[0];
        for (int i = 1; i < held; i++) begin
          held_keys[i-1]     = held_keys[i];
          held_payloads[i-1] = held_payloads[i];
        end
        held--;
      end
      if (held > 0) begin
        w.head_valid   = 1'b1;
        w.head_key     = held_keys[0];
        w.head_payload = held_payloads[0];
      end
      w.entry_count = count_t'(held);
      expected_rsp.push_back(w);
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    // Compare one accepted response word with the oldest prediction.
    function void check_response(rsp_word_t got);
      rsp_word_t want;
      if (expected_rsp.size() == 0) begin
        $error("response word with no request outstanding");
        failures++;
        return;
      end
      want = expected_rsp.pop_front();
      check_field("ok", 64'(want.ok), 64'(got.ok));
      check_field("popped_key", 64'(want.popped_key), 64'(got.popped_key));
      check_field("popped_payload", 64'(want.popped_payload), 64'(got.popped_payload));
      check_field("head_valid", 64'(want.head_valid), 64'(got.head_valid));
      check_field("head_key", 64'(want.head_key), 64'(got.head_key));
      check_field("head_payload", 64'(want.head_payload), 64'(got.head_payload));
      check_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
    endfunction
  endclass

endpackage

[tb/sv/sorted_priority_queue_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test
// Self-checking bench for the sorted priority queue: directed push and pop
// words, then random traffic under both serve orders and three idle mixes,
// each response compared against a scoreboard that keeps its own store.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  // cycles without any accepted word before the run is declared hung
  localparam int STALL_LIMIT = 2000;
  // request words per random phase; six phases give about 900 words
  localparam int PHASE_WORDS = 150;
  localparam int NUM_PHASES  = 6;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic          cfg_wdata;
  int            send_idle_pct;
  int            rsp_idle_pct;
  int            stall_cycles;
  spq_scoreboard sb;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  sorted_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  always #6 clk = ~clk;

  // Response side: drop ready at random, decided on the falling edge so the
  // value is settled well before the block samples it.
  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(99) >= rsp_idle_pct);
  end

  // Sample both channels and the register port on the rising edge. A request
  // is noted before the response check, so the scoreboard queue is always in
  // accept order.
  always @(posedge clk) begin : monitor
    rsp_word_t got;
    bit        moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_we) begin
        sb.set_order(cfg_wdata);
      end
      if (req_ch.valid && req_ch.ready) begin
        sb.note_request(req_ch.mode, req_ch.item_key, req_ch.item_payload);
        moved = 1'b1;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.ok             = rsp_ch.ok;
        got.popped_key     = rsp_ch.popped_key;
        got.popped_payload = rsp_ch.popped_payload;
        got.head_valid     = rsp_ch.head_valid;
        got.head_key       = rsp_ch.head_key;
        got.head_payload   = rsp_ch.head_payload;
        got.entry_count    = rsp_ch.entry_count;
        sb.check_response(got);
        moved = 1'b1;
      end
    end
    stall_cycles = moved ? 0 : stall_cycles + 1;
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // Drive one request word. Entered and left on a falling edge; valid stays
  // high into the next word unless the sender chooses to idle first.
  task automatic send_word(logic mode, logic [KEY_WIDTH-1:0] key,
                           logic [PAYLOAD_WIDTH-1:0] payload);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid        = 1'b1;
    req_ch.mode         = mode;
    req_ch.item_key     = key;
    req_ch.item_payload = payload;
    // hold the word until the block takes it
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic pop_word();
    send_word(MODE_POP, KEY_WIDTH'($urandom), $urandom);
  endtask

  // Hold off the sender until every predicted response has been seen, then
  // let the response register settle.
  task automatic drain_responses();
    req_ch.valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Write the serve order; only called with the block idle.
  task automatic write_order(bit value);
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Mix of extremes, a narrow range that forces equal keys, and full range.
  function automatic logic [KEY_WIDTH-1:0] pick_key(bit ties);
    int r;
    r = $urandom_range(9);
    if (ties) return KEY_WIDTH'($urandom_range(3));
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return KEY_WIDTH'($urandom_range(7));
    return KEY_WIDTH'($urandom);
  endfunction

  function automatic logic [PAYLOAD_WIDTH-1:0] pick_payload();
    int r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // Random traffic in runs: mixed push/pop, push bursts that run into a full
  // queue, pop bursts that run past empty, and runs of tied keys.
  task automatic random_traffic(int words);
    int   sent;
    int   kind;
    int   len;
    int   push_pct;
    logic mode;
    sent = 0;
    while (sent < words) begin
      kind     = $urandom_range(99);
      len      = $urandom_range(1, 20);
      push_pct = $urandom_range(30, 70);
      for (int j = 0; j < len; j++) begin
        if (kind < 40) mode = ($urandom_range(99) < push_pct) ? MODE_PUSH : MODE_POP;
        else if (kind < 60) mode = MODE_PUSH;
        else if (kind < 80) mode = MODE_POP;
        else mode = $urandom_range(1) ? MODE_PUSH : MODE_POP;
        send_word(mode, pick_key(kind >= 80), pick_payload());
        sent++;
      end
    end
  endtask

  initial begin
    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_wdata           = 1'b0;
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_PUSH;
    req_ch.item_key     = '0;
    req_ch.item_payload = '0;
    rsp_ch.ready        = 1'b0;
    send_idle_pct       = 18;
    rsp_idle_pct        = 51;
    sb                  = new();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part, smallest key first (reset order).
    // Pop on an empty queue is rejected.
    pop_word();
    // Equal keys must leave in arrival order; key and payload extremes.
    send_word(MODE_PUSH, 16'h1234, 32'h0000_000A);
    send_word(MODE_PUSH, 16'h1234, 32'h0000_000B);
    send_word(MODE_PUSH, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(MODE_PUSH, 16'h0000, 32'h0000_0000);
    send_word(MODE_PUSH, 16'h8000, 32'h5555_AAAA);
    // Drain everything and one more, which hits empty again.
    repeat (6) pop_word();

    // Leave entries held, flip the order, then push into the unsorted store.
    send_word(MODE_PUSH, 16'd7, 32'd1);
    send_word(MODE_PUSH, 16'd3, 32'd2);
    send_word(MODE_PUSH, 16'd9, 32'd3);
    drain_responses();
    write_order(1'b1);
    send_word(MODE_PUSH, 16'd5, 32'd4);
    send_word(MODE_PUSH, 16'd5, 32'd5);
    send_word(MODE_PUSH, 16'hFFFF, 32'd6);
    repeat (7) pop_word();

    // Random phases: sender 18 / receiver 51 percent idle, then swapped,
    // then no idling. Order alternates each phase; entries held across a
    // write stay in place.
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase < 2) begin
        send_idle_pct = 18;
        rsp_idle_pct  = 51;
      end else if (phase < 4) begin
        send_idle_pct = 51;
        rsp_idle_pct  = 18;
      end else begin
        send_idle_pct = 0;
        rsp_idle_pct  = 0;
      end
      drain_responses();
      write_order((phase % 2) == 0);
      random_traffic(PHASE_WORDS);
    end

    // Wait out the last responses plus the response latency, then report.
    drain_responses();
    repeat (4) @(posedge clk);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_req_if.sv
rtl/core/spq_rsp_if.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue.sv
tb/sv/spq_tb_pkg.sv
tb/sv/sorted_priority_queue_test.sv
